// ----- src/pfr_pkg.sv -----
// ----------------------------------------------------------------------------
// pfr_pkg: shared constants and types for the frame RMS level block
// Sizes of the sample, square, sum and count paths, the frame record that
// travels through the queue, and the back-end states.
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int MAX_FRAME_SAMPLES = 1024;

    localparam int SAMPLE_W   = 16;
    localparam int SQ_W       = 31;
    localparam int CNT_W      = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int SUM_W      = SQ_W + $clog2(MAX_FRAME_SAMPLES);
    localparam int LEVEL_W    = 16;
    localparam int RAD_W      = 2 * LEVEL_W;
    localparam int ROOT_STEPS = LEVEL_W;
    localparam int REM_W      = LEVEL_W + 2;
    localparam int STEP_W     = $clog2(SUM_W);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QLVL_W     = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             overflow;
    } frame_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROOT,
        ST_OUT
    } back_state_t;

endpackage

// ----- src/pfr_front.sv -----
// ----------------------------------------------------------------------------
// pfr_front: sample intake and square accumulation
// Takes one sample a cycle while the queue has room, squares its magnitude,
// adds it to the sum within the frame limit, and queues each closed frame.
// ----------------------------------------------------------------------------
module pfr_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [pfr_pkg::SAMPLE_W-1:0]     in_sample,
    input  logic                             in_last,
    input  logic [pfr_pkg::QLVL_W-1:0]       q_level,
    output logic                             push,
    output pfr_pkg::frame_t                  push_data
);

    logic [pfr_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [pfr_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                         ovf_reg, ovf_next;
    logic [pfr_pkg::SQ_W-1:0]     sq_reg, sq_next;
    logic                         close_reg, close_next;
    logic [pfr_pkg::CNT_W-1:0]    st_count_reg, st_count_next;
    logic                         st_ovf_reg, st_ovf_next;

    logic                         accept;
    logic                         take;
    logic [pfr_pkg::SAMPLE_W-1:0] mag;
    logic [2*pfr_pkg::SAMPLE_W-1:0] prod;
    logic [pfr_pkg::CNT_W-1:0]    count_inc;
    logic [pfr_pkg::SUM_W-1:0]    sum_add;

    assign in_ready = ({1'b0, q_level} + {{pfr_pkg::QLVL_W{1'b0}}, close_reg})
                      < (pfr_pkg::QLVL_W + 1)'(pfr_pkg::QDEPTH);
    assign accept   = in_valid && in_ready;
    assign take     = count_reg < pfr_pkg::CNT_W'(pfr_pkg::MAX_FRAME_SAMPLES);
    assign mag      = in_sample[pfr_pkg::SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
    assign prod     = mag * mag;
    assign count_inc = take ? (count_reg + 1'b1) : count_reg;
    assign sum_add  = sum_reg + pfr_pkg::SUM_W'(sq_reg);

    always_comb
    begin
        sq_next       = '0;
        close_next    = 1'b0;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        st_count_next = st_count_reg;
        st_ovf_next   = st_ovf_reg;
        if (accept)
        begin
            sq_next = take ? prod[pfr_pkg::SQ_W-1:0] : '0;
            if (in_last)
            begin
                close_next    = 1'b1;
                st_count_next = count_inc;
                st_ovf_next   = ovf_reg || !take;
                count_next    = '0;
                ovf_next      = 1'b0;
            end
            else
            begin
                count_next = count_inc;
                ovf_next   = ovf_reg || !take;
            end
        end
        sum_next = close_reg ? '0 : sum_add;
    end

    assign push               = close_reg;
    assign push_data.sum      = sum_add;
    assign push_data.count    = st_count_reg;
    assign push_data.overflow = st_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            sq_reg    <= '0;
            close_reg <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            sq_reg    <= sq_next;
            close_reg <= close_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_count_reg <= st_count_next;
        st_ovf_reg   <= st_ovf_next;
    end

endmodule

// ----- src/pfr_queue.sv -----
// ----------------------------------------------------------------------------
// pfr_queue: closed-frame queue
// A short first-in first-out store of frame records between the intake and
// the divide and root unit.
// ----------------------------------------------------------------------------
module pfr_queue
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  pfr_pkg::frame_t              push_data,
    input  logic                         pop,
    output logic                         q_valid,
    output pfr_pkg::frame_t              q_data,
    output logic [pfr_pkg::QLVL_W-1:0]   q_level
);

    pfr_pkg::frame_t                mem [pfr_pkg::QDEPTH];
    logic [pfr_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [pfr_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [pfr_pkg::QLVL_W-1:0]     level_reg, level_next;
    logic                           do_pop;

    assign q_valid = level_reg != '0;
    assign q_data  = mem[rd_ptr_reg];
    assign q_level = level_reg;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        level_next  = level_reg + {{(pfr_pkg::QLVL_W-1){1'b0}}, push}
                      - {{(pfr_pkg::QLVL_W-1){1'b0}}, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/pfr_back.sv -----
// ----------------------------------------------------------------------------
// pfr_back: mean and root unit
// Divides a frame's square sum by its sample count one bit a cycle, takes the
// floor square root two radicand bits a cycle and holds the result.
// ----------------------------------------------------------------------------
module pfr_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  pfr_pkg::frame_t               q_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pfr_pkg::LEVEL_W-1:0]   out_level,
    output logic                          out_overflow
);

    pfr_pkg::back_state_t             state_reg, state_next;
    logic [pfr_pkg::STEP_W-1:0]       step_reg, step_next;
    logic [pfr_pkg::SUM_W-1:0]        dq_reg, dq_next;
    logic [pfr_pkg::CNT_W-1:0]        drem_reg, drem_next;
    logic [pfr_pkg::CNT_W-1:0]        div_reg, div_next;
    logic [pfr_pkg::RAD_W-1:0]        rad_reg, rad_next;
    logic [pfr_pkg::REM_W-1:0]        rrem_reg, rrem_next;
    logic [pfr_pkg::LEVEL_W-1:0]      root_reg, root_next;
    logic                             zero_reg, zero_next;
    logic                             ovf_reg, ovf_next;
    logic [pfr_pkg::LEVEL_W-1:0]      level_reg, level_next;

    logic [pfr_pkg::CNT_W:0]          dtrial;
    logic                             dbit;
    logic [pfr_pkg::CNT_W-1:0]        drem_step;
    logic [pfr_pkg::SUM_W-1:0]        dq_step;
    logic [pfr_pkg::REM_W+1:0]        rshift;
    logic [pfr_pkg::REM_W+1:0]        rtrial;
    logic                             rbit;
    logic [pfr_pkg::REM_W-1:0]        rrem_step;
    logic [pfr_pkg::LEVEL_W-1:0]      root_step;

    always_comb
    begin
        dtrial    = {drem_reg, dq_reg[pfr_pkg::SUM_W-1]};
        dbit      = dtrial >= {1'b0, div_reg};
        drem_step = dbit ? pfr_pkg::CNT_W'(dtrial - {1'b0, div_reg})
                         : dtrial[pfr_pkg::CNT_W-1:0];
        dq_step   = {dq_reg[pfr_pkg::SUM_W-2:0], dbit};

        rshift    = {rrem_reg, rad_reg[pfr_pkg::RAD_W-1 -: 2]};
        rtrial    = {2'b00, root_reg, 2'b01};
        rbit      = rshift >= rtrial;
        rrem_step = rbit ? pfr_pkg::REM_W'(rshift - rtrial)
                         : rshift[pfr_pkg::REM_W-1:0];
        root_step = {root_reg[pfr_pkg::LEVEL_W-2:0], rbit};
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dq_next    = dq_reg;
        drem_next  = drem_reg;
        div_next   = div_reg;
        rad_next   = rad_reg;
        rrem_next  = rrem_reg;
        root_next  = root_reg;
        zero_next  = zero_reg;
        ovf_next   = ovf_reg;
        level_next = level_reg;
        pop        = 1'b0;
        unique case (state_reg)
            pfr_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    dq_next    = q_data.sum;
                    drem_next  = '0;
                    div_next   = q_data.count;
                    zero_next  = q_data.count == '0;
                    ovf_next   = q_data.overflow;
                    step_next  = '0;
                    state_next = pfr_pkg::ST_DIV;
                end
            end
            pfr_pkg::ST_DIV:
            begin
                dq_next   = dq_step;
                drem_next = drem_step;
                step_next = step_reg + 1'b1;
                if (step_reg == pfr_pkg::STEP_W'(pfr_pkg::SUM_W - 1))
                begin
                    rad_next   = {1'b0, dq_step[pfr_pkg::RAD_W-2:0]};
                    rrem_next  = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = pfr_pkg::ST_ROOT;
                end
            end
            pfr_pkg::ST_ROOT:
            begin
                rad_next  = {rad_reg[pfr_pkg::RAD_W-3:0], 2'b00};
                rrem_next = rrem_step;
                root_next = root_step;
                step_next = step_reg + 1'b1;
                if (step_reg == pfr_pkg::STEP_W'(pfr_pkg::ROOT_STEPS - 1))
                begin
                    level_next = zero_reg ? '0 : root_step;
                    state_next = pfr_pkg::ST_OUT;
                end
            end
            pfr_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = pfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfr_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid    = state_reg == pfr_pkg::ST_OUT;
    assign out_level    = level_reg;
    assign out_overflow = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfr_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg    <= dq_next;
        drem_reg  <= drem_next;
        div_reg   <= div_next;
        rad_reg   <= rad_next;
        rrem_reg  <= rrem_next;
        root_reg  <= root_next;
        zero_reg  <= zero_next;
        ovf_reg   <= ovf_next;
        level_reg <= level_next;
    end

endmodule

// ----- src/pcm_frame_rms.sv -----
// ----------------------------------------------------------------------------
// pcm_frame_rms: frame RMS level of signed 16-bit PCM samples
// Sums sample squares over a frame closed by tlast, then gives the floor
// square root of the floored mean square and a frame overflow flag.
//
//   Channel  | Direction | tdata                  | tlast        | tuser
//   s_axis   | in        | [15:0] sample          | last_sample  | -
//   m_axis   | out       | [15:0] rms_level       | -            | frame_overflow
//
// Samples are taken one a cycle while intake is not stalled; the frame limit
// is 1024 samples. A closed frame enters the queue in the cycle after its last
// item and leaves it when the divide and root unit is idle; the unit then runs
// the divider and the square root before the level is offered.
// The queue holds two closed frames; intake stalls while it is full, counting
// a frame that is about to enter it. Reset clears the sum, count and control.
// ----------------------------------------------------------------------------
module pcm_frame_rms
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] rms_level
    output logic        m_axis_tuser    // [0] frame_overflow
);

    logic                               push;
    pfr_pkg::frame_t                    push_data;
    logic                               pop;
    logic                               q_valid;
    pfr_pkg::frame_t                    q_data;
    logic [pfr_pkg::QLVL_W-1:0]         q_level;

    pfr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .q_level   (q_level),
        .push      (push),
        .push_data (push_data)
    );

    pfr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_level   (q_level)
    );

    pfr_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_level    (m_axis_tdata),
        .out_overflow (m_axis_tuser)
    );

endmodule
